// ===== hw/rtl/fr_pkg.sv =====
// ----------------------------------------------------------------------------
// fr_pkg
// Shared constants and controller/datapath command and status types for the
// fraction reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package fr_pkg;

  // default width of numerator and denominator
  localparam int unsigned VALUE_BITS_DEF = 31;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new fraction
    logic gcd_step;  // one binary gcd step
    logic div_init;  // form the divisor and clear the remainders
    logic div_step;  // one restoring division bit on both values
    logic out_load;  // write the result register
  } fr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic den_zero;  // captured denominator is zero
    logic gcd_done;  // one gcd operand has reached zero
    logic div_last;  // final division bit in progress
  } fr_status_t;

endpackage : fr_pkg

`default_nettype wire

// ===== hw/rtl/fr_in_if.sv =====
// ----------------------------------------------------------------------------
// fr_in_if
// Input channel: one fraction per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fr_in_if #(
  parameter int unsigned VALUE_BITS = fr_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] numerator;
  logic [VALUE_BITS-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface : fr_in_if

// ----------------------------------------------------------------------------
// fr_out_if
// Output channel: one reduced fraction per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fr_out_if #(
  parameter int unsigned VALUE_BITS = fr_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] reduced_numerator;
  logic [VALUE_BITS-1:0] reduced_denominator;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  output ready);
endinterface : fr_out_if

`default_nettype wire

// ===== hw/rtl/fraction_reducer.sv =====
// ----------------------------------------------------------------------------
// fraction_reducer
// Reduces a fraction to lowest terms: binary gcd, then exact division of
// numerator and denominator by the gcd.
//
//   channel  direction  payload                                      handshake
//   in_i     in         numerator, denominator                       valid/ready
//   out_o    out        reduced_numerator, reduced_denominator       valid/ready
//
// One fraction at a time. An item passes through a load, the gcd steps
// (a subtract is always followed by a shift, each shift drops one operand
// bit), forming the divisor, one division step per quotient bit and the
// result write.
// A zero denominator skips straight to the result and gives 0/0.
// The result sits in its own register, so the next fraction is taken while
// the previous result still waits; reset clears only the control state.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reducer #(
  parameter int unsigned VALUE_BITS = fr_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fr_in_if.sink     in_i,
  fr_out_if.source  out_o
);
  import fr_pkg::*;

  fr_cmd_t    cmd;
  fr_status_t status;

  // control
  fr_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // arithmetic
  fr_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .numerator_i           (in_i.numerator),
    .denominator_i         (in_i.denominator),
    .reduced_numerator_o   (out_o.reduced_numerator),
    .reduced_denominator_o (out_o.reduced_denominator)
  );

endmodule : fraction_reducer

`default_nettype wire

// ===== hw/rtl/fr_datapath.sv =====
// ----------------------------------------------------------------------------
// fr_datapath
// Binary gcd registers, two restoring dividers sharing one bit counter, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fr_datapath #(
  parameter int unsigned VALUE_BITS = fr_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  fr_pkg::fr_cmd_t       cmd_i,
  output fr_pkg::fr_status_t    status_o,
  input  logic [VALUE_BITS-1:0] numerator_i,
  input  logic [VALUE_BITS-1:0] denominator_i,
  output logic [VALUE_BITS-1:0] reduced_numerator_o,
  output logic [VALUE_BITS-1:0] reduced_denominator_o
);
  import fr_pkg::*;

  localparam int unsigned KW = $clog2(VALUE_BITS + 1);
  localparam int unsigned CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]         k_q, k_d;
  logic [VALUE_BITS-1:0] g_q, g_d;
  logic [VALUE_BITS-1:0] qn_q, qn_d, qd_q, qd_d;
  logic [VALUE_BITS-1:0] rn_q, rn_d, rd_q, rd_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  den_zero_q, den_zero_d;
  logic [VALUE_BITS-1:0] res_num_q, res_num_d, res_den_q, res_den_d;

  logic [VALUE_BITS:0]   rn_sh, rd_sh, g_ext;
  logic                  rn_ge, rd_ge;

  // binary gcd: strip common twos, strip single twos, subtract odd values
  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    k_d        = k_q;
    den_zero_d = den_zero_q;
    if (cmd_i.load) begin
      a_d        = numerator_i;
      b_d        = denominator_i;
      k_d        = '0;
      den_zero_d = (denominator_i == '0);
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  // restoring division, one quotient bit per cycle on both values
  assign g_ext = {1'b0, g_q};
  assign rn_sh = {rn_q, qn_q[VALUE_BITS-1]};
  assign rd_sh = {rd_q, qd_q[VALUE_BITS-1]};
  assign rn_ge = (rn_sh >= g_ext);
  assign rd_ge = (rd_sh >= g_ext);

  always_comb begin
    g_d   = g_q;
    qn_d  = qn_q;
    qd_d  = qd_q;
    rn_d  = rn_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      qn_d = numerator_i;
      qd_d = denominator_i;
    end else if (cmd_i.div_init) begin
      // one operand is zero here, so the or gives the odd part of the gcd
      g_d   = (a_q | b_q) << k_q;
      rn_d  = '0;
      rd_d  = '0;
      cnt_d = CW'(VALUE_BITS - 1);
    end else if (cmd_i.div_step) begin
      rn_d  = rn_ge ? VALUE_BITS'(rn_sh - g_ext) : rn_sh[VALUE_BITS-1:0];
      rd_d  = rd_ge ? VALUE_BITS'(rd_sh - g_ext) : rd_sh[VALUE_BITS-1:0];
      qn_d  = {qn_q[VALUE_BITS-2:0], rn_ge};
      qd_d  = {qd_q[VALUE_BITS-2:0], rd_ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // result register, zero denominator gives 0/0
  always_comb begin
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    if (cmd_i.out_load) begin
      res_num_d = den_zero_q ? '0 : qn_q;
      res_den_d = den_zero_q ? '0 : qd_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    k_q        <= k_d;
    g_q        <= g_d;
    qn_q       <= qn_d;
    qd_q       <= qd_d;
    rn_q       <= rn_d;
    rd_q       <= rd_d;
    cnt_q      <= cnt_d;
    den_zero_q <= den_zero_d;
    res_num_q  <= res_num_d;
    res_den_q  <= res_den_d;
  end

  // status back to the controller
  assign status_o.den_zero = den_zero_q;
  assign status_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign status_o.div_last = (cnt_q == '0);

  assign reduced_numerator_o   = res_num_q;
  assign reduced_denominator_o = res_den_q;

endmodule : fr_datapath

`default_nettype wire

// ===== hw/rtl/fr_controller.sv =====
// ----------------------------------------------------------------------------
// fr_controller
// Sequencer for load, gcd, division and result phases; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fr_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fr_pkg::fr_cmd_t    cmd_o,
  input  fr_pkg::fr_status_t status_i
);
  import fr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GCD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } fr_state_e;

  fr_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status_i.den_zero) begin
          state_d = ST_EMIT;
        end else if (status_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag, held until the transfer
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : fr_controller

`default_nettype wire
